// ===== rtl/core/hsg_pkg.sv =====
package hsg_pkg;

  // Default build limits for the frame size.
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Frame size after reset, before any register write.
  localparam int DIM_RESET = 4096;

  // Field widths of the item and result beats.
  localparam int SAMPLE_W = 16;
  localparam int SLOPE_W  = 29;
  localparam int POS_W    = 12;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Saturation limits of a slope.
  localparam int SLOPE_MAX = (2 ** (SLOPE_W - 1)) - 1;
  localparam int SLOPE_MIN = -(2 ** (SLOPE_W - 1));

  // Queue depths; both must be powers of two.
  localparam int JOB_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Result slots one input pixel can release, in output order.
  localparam int NUM_EMIT     = 4;
  localparam int EM_UPPER_LAG = 0;  // pixel (c-1, r-1)
  localparam int EM_UPPER_END = 1;  // pixel (c, r-1) at the end of a row
  localparam int EM_LOWER_LAG = 2;  // pixel (c-1, r) on the last row
  localparam int EM_LOWER_END = 3;  // pixel (c, r) at the end of the last row

  // One image column around the current row: rows r, r-1 and r-2.
  typedef struct packed {
    logic [SAMPLE_W-1:0] cur;
    logic [SAMPLE_W-1:0] up1;
    logic [SAMPLE_W-1:0] up2;
  } column_t;

  // Classification the front end attaches to each job.
  typedef struct packed {
    logic [NUM_EMIT-1:0] emit;
    logic                col_ge1;
    logic                row_ge1;
    logic                row_ge2;
  } job_flags_t;

  // One result beat.
  typedef struct packed {
    logic signed [SLOPE_W-1:0] slope_x;
    logic signed [SLOPE_W-1:0] slope_y;
    logic [POS_W-1:0]          out_col;
    logic [POS_W-1:0]          out_row;
    logic                      last_of_run;
    logic                      end_of_frame;
  } result_t;

  // Width of a job word: three columns, flags, column and row position.
  function automatic int job_w(input int cw, input int rw);
    return 3 * $bits(column_t) + $bits(job_flags_t) + cw + rw;
  endfunction

endpackage

// ===== rtl/core/hsg_ram.sv =====
module hsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data (old data on collision).
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/hsg_fifo.sv =====
module hsg_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    head;
  logic [PW-1:0]    tail;

  // Storage; the writer never pushes into a full queue.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= wdata;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata = slots[head];
  assign empty = (count == '0);

endmodule

// ===== rtl/core/hsg_front.sv =====
module hsg_front #(
  parameter int MAX_WIDTH  = hsg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  restart,
  input  logic [$clog2(MAX_WIDTH)-1:0]          w_last,
  input  logic [$clog2(MAX_HEIGHT)-1:0]         h_last,
  input  logic                                  push,
  input  logic [hsg_pkg::SAMPLE_W-1:0]          height_sample,
  output logic                                  full,
  input  logic [$clog2(hsg_pkg::JOB_DEPTH+1)-1:0] job_count,
  output logic                                  job_push,
  output logic [hsg_pkg::job_w($clog2(MAX_WIDTH), $clog2(MAX_HEIGHT))-1:0] job_data
);

  import hsg_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CNT_W = $clog2(JOB_DEPTH + 1);
  localparam int LW    = 2 * SAMPLE_W;

  logic          accept;
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [CW-1:0]       s1_col;
  logic [RW-1:0]       s1_row;
  logic                s1_col_ge1;
  logic                s1_col_ge2;
  logic                s1_col_last;
  logic                s1_row_ge1;
  logic                s1_row_ge2;
  logic                s1_row_last;

  logic          byp_hit;
  logic [LW-1:0] byp_data;
  logic [LW-1:0] ram_rdata;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] line_rd;

  column_t    cur_col;
  column_t    win1;
  column_t    win2;
  column_t    left_col;
  job_flags_t flags;

  // Reserve a queue slot for the beat in flight as well as the new one.
  assign full   = ({1'b0, job_count} + (CNT_W+1)'(s1_valid)) >= (CNT_W+1)'(JOB_DEPTH);
  assign accept = push && !full;

  // Raster position of the next input beat.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col == w_last) begin
        col <= '0;
        row <= (row == h_last) ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Stage 1 control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Stage 1 payload and position classification.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= height_sample;
      s1_col      <= col;
      s1_row      <= row;
      s1_col_ge1  <= (col != '0);
      s1_col_ge2  <= ({1'b0, col} > (CW+1)'(1));
      s1_col_last <= (col == w_last);
      s1_row_ge1  <= (row != '0);
      s1_row_ge2  <= ({1'b0, row} > (RW+1)'(1));
      s1_row_last <= (row == h_last);
      // A read that collides with the write of the previous beat takes its data.
      byp_hit     <= s1_valid && (s1_col == col);
      byp_data    <= ram_wdata;
    end
  end

  // Both line stores share one word: previous row on top, older row below.
  hsg_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  // Current column and the line store update, which shifts each row down.
  always_comb begin
    line_rd     = byp_hit ? byp_data : ram_rdata;
    cur_col.cur = s1_sample;
    cur_col.up1 = line_rd[LW-1:SAMPLE_W];
    cur_col.up2 = line_rd[SAMPLE_W-1:0];
    ram_wdata   = {s1_sample, cur_col.up1};
  end

  // Window of the two previous columns of the current row.
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      win1 <= cur_col;
      win2 <= win1;
    end
  end

  // Decide which results this beat releases and hand the job on.
  always_comb begin
    left_col                 = s1_col_ge2 ? win2 : win1;
    flags.emit[EM_UPPER_LAG] = s1_row_ge1 && s1_col_ge1;
    flags.emit[EM_UPPER_END] = s1_row_ge1 && s1_col_last;
    flags.emit[EM_LOWER_LAG] = s1_row_last && s1_col_ge1;
    flags.emit[EM_LOWER_END] = s1_row_last && s1_col_last;
    flags.col_ge1            = s1_col_ge1;
    flags.row_ge1            = s1_row_ge1;
    flags.row_ge2            = s1_row_ge2;
    job_push                 = s1_valid && (|flags.emit);
    job_data                 = {cur_col, win1, left_col, flags, s1_col, s1_row};
  end

endmodule

// ===== rtl/core/hsg_back.sv =====
module hsg_back #(
  parameter int MAX_WIDTH  = hsg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]   frame_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]  frame_h,
  input  logic [hsg_pkg::job_w($clog2(MAX_WIDTH), $clog2(MAX_HEIGHT))-1:0] job_data,
  input  logic                             job_empty,
  output logic                             job_pop,
  input  logic                             pop,
  output logic                             empty,
  output hsg_pkg::result_t                 result
);

  import hsg_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int MAXD_W = (DIM_W > HDIM_W) ? DIM_W : HDIM_W;
  localparam int PXW    = ((MAXD_W + 18) > 30) ? (MAXD_W + 18) : 30;
  localparam int OCW    = $clog2(OUT_DEPTH + 1);
  localparam int DFW    = SAMPLE_W + 1;

  localparam logic signed [PXW-1:0] SAT_HI = PXW'(SLOPE_MAX);
  localparam logic signed [PXW-1:0] SAT_LO = PXW'(SLOPE_MIN);

  column_t       j_cur;
  column_t       j_prev;
  column_t       j_left;
  job_flags_t    j_flags;
  logic [CW-1:0] j_col;
  logic [RW-1:0] j_row;

  logic [NUM_EMIT-1:0] done;
  logic [NUM_EMIT-1:0] remaining;
  logic [NUM_EMIT-1:0] sel;
  logic                last_em;
  logic                credit;
  logic                issue;

  logic                      lag;
  logic                      upper;
  column_t                   center;
  column_t                   left;
  logic [SAMPLE_W-1:0]       right_v;
  logic [SAMPLE_W-1:0]       left_v;
  logic [SAMPLE_W-1:0]       bot_v;
  logic [CW-1:0]             em_col;
  logic [RW-1:0]             em_row;
  logic signed [DFW-1:0]     dx_next;
  logic signed [DFW-1:0]     dy_next;

  logic                  b1_valid;
  logic signed [DFW-1:0] b1_dx;
  logic signed [DFW-1:0] b1_dy;
  logic [POS_W-1:0]      b1_col;
  logic [POS_W-1:0]      b1_row;
  logic                  b1_last;
  logic                  b1_eof;

  logic                  b2_valid;
  logic signed [PXW-1:0] b2_px;
  logic signed [PXW-1:0] b2_py;
  logic [POS_W-1:0]      b2_col;
  logic [POS_W-1:0]      b2_row;
  logic                  b2_last;
  logic                  b2_eof;

  result_t        res_in;
  logic [OCW-1:0] out_count;

  function automatic logic signed [SLOPE_W-1:0] saturate(input logic signed [PXW-1:0] p);
    logic signed [SLOPE_W-1:0] s;
    if (p > SAT_HI) begin
      s = SLOPE_W'(SLOPE_MAX);
    end else if (p < SAT_LO) begin
      s = SLOPE_W'(SLOPE_MIN);
    end else begin
      s = p[SLOPE_W-1:0];
    end
    return s;
  endfunction

  assign {j_cur, j_prev, j_left, j_flags, j_col, j_row} = job_data;

  // Walk the released slots of the head job, lowest first, one a cycle while the result queue has room.
  always_comb begin
    remaining = j_flags.emit & ~done;
    sel       = remaining & (~remaining + NUM_EMIT'(1));
    last_em   = (remaining == sel);
    credit    = ({1'b0, out_count} + (OCW+1)'(b1_valid) + (OCW+1)'(b2_valid))
                < (OCW+1)'(OUT_DEPTH);
    issue     = !job_empty && credit;
    job_pop   = issue && last_em;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (issue) begin
      done <= last_em ? '0 : (done | sel);
    end
  end

  // Neighbor selection: lagging slots center on column c-1, upper ones on row r-1.
  always_comb begin
    lag     = sel[EM_UPPER_LAG] || sel[EM_LOWER_LAG];
    upper   = sel[EM_UPPER_LAG] || sel[EM_UPPER_END];
    center  = lag ? j_prev : j_cur;
    left    = lag ? j_left : (j_flags.col_ge1 ? j_prev : j_cur);
    right_v = upper ? j_cur.up1 : j_cur.cur;
    left_v  = upper ? left.up1 : left.cur;
    if (upper) begin
      bot_v = j_flags.row_ge2 ? center.up2 : center.up1;
    end else begin
      bot_v = j_flags.row_ge1 ? center.up1 : center.cur;
    end
    dx_next = $signed({1'b0, right_v}) - $signed({1'b0, left_v});
    dy_next = $signed({1'b0, center.cur}) - $signed({1'b0, bot_v});
    em_col  = lag ? j_col - CW'(1) : j_col;
    em_row  = upper ? j_row - RW'(1) : j_row;
  end

  // Differences stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b1_dx   <= dx_next;
      b1_dy   <= dy_next;
      b1_col  <= POS_W'(em_col);
      b1_row  <= POS_W'(em_row);
      b1_last <= last_em;
      b1_eof  <= sel[EM_LOWER_END];
    end
  end

  // Scaling stage: frame size times difference.
  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else begin
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      b2_px   <= $signed({{(PXW-DIM_W){1'b0}}, frame_w}) * PXW'(b1_dx);
      b2_py   <= $signed({{(PXW-HDIM_W){1'b0}}, frame_h}) * PXW'(b1_dy);
      b2_col  <= b1_col;
      b2_row  <= b1_row;
      b2_last <= b1_last;
      b2_eof  <= b1_eof;
    end
  end

  // Clip to the slope range and queue the beat.
  always_comb begin
    res_in.slope_x      = saturate(b2_px);
    res_in.slope_y      = saturate(b2_py);
    res_in.out_col      = b2_col;
    res_in.out_row      = b2_row;
    res_in.last_of_run  = b2_last;
    res_in.end_of_frame = b2_eof;
  end

  hsg_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (b2_valid),
    .wdata (res_in),
    .pop   (pop && !empty),
    .rdata (result),
    .empty (empty),
    .count (out_count)
  );

endmodule

// ===== rtl/core/heightmap_slope_gradient_unit.sv =====
// Central-difference slope unit for a 16-bit height map.
// Input queue port: one height pixel per beat in raster order, taken when
// push is high and full is low. Result queue port: the oldest result is shown
// while empty is low and leaves when pop is high. Each result carries
// frame_width*(right-left), frame_height*(top-bottom), its pixel position,
// a flag on the last result of its input pixel, and an end-of-frame flag.
// Results run one row behind the input; the last row comes out as it arrives.
// Throughput: one pixel per cycle while full is low; the back end issues one
// result per cycle while the result queue has room, so at row ends and on the
// last row, where one pixel releases two to four results, full can rise. The
// line store holds one word per column, is read when a pixel is taken and is
// written in the next cycle, with a bypass for back-to-back same columns.
// Configuration: write index 0 (frame width) or 1 (frame height) only while
// idle; any such write restarts the frame at pixel (0, 0). cfg_ready is always
// high. Reset clears position, queues and pipeline and sets both sizes to 4096
// or the maximum if smaller; the line store is not cleared, and its data is
// used only where it has been written. When pop stays low, results collect in
// a small queue and full rises shortly after; nothing is dropped.
module heightmap_slope_gradient_unit #(
  parameter int MAX_WIDTH  = hsg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = hsg_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic [hsg_pkg::SAMPLE_W-1:0]        height_sample,
  output logic                                full,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [hsg_pkg::SLOPE_W-1:0]  slope_x,
  output logic signed [hsg_pkg::SLOPE_W-1:0]  slope_y,
  output logic [hsg_pkg::POS_W-1:0]           out_col,
  output logic [hsg_pkg::POS_W-1:0]           out_row,
  output logic                                last_of_run,
  output logic                                end_of_frame,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hsg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import hsg_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DIM_W  = $clog2(MAX_WIDTH + 1);
  localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
  localparam int JOB_W  = job_w(CW, RW);
  localparam int JCNT_W = $clog2(JOB_DEPTH + 1);
  localparam int WCMP_W = (DIM_W > CFG_DATA_W) ? DIM_W : CFG_DATA_W;
  localparam int HCMP_W = (HDIM_W > CFG_DATA_W) ? HDIM_W : CFG_DATA_W;

  localparam logic [DIM_W-1:0]  W_RESET =
    DIM_W'((DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET);
  localparam logic [HDIM_W-1:0] H_RESET =
    HDIM_W'((DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET);

  logic [DIM_W-1:0]  frame_w;
  logic [HDIM_W-1:0] frame_h;
  logic [DIM_W-1:0]  w_clamped;
  logic [HDIM_W-1:0] h_clamped;
  logic [WCMP_W-1:0] cfg_w_ext;
  logic [HCMP_W-1:0] cfg_h_ext;
  logic              cfg_write;
  logic              restart;
  logic [CW-1:0]     w_last;
  logic [RW-1:0]     h_last;

  logic              job_push;
  logic [JOB_W-1:0]  job_wdata;
  logic [JOB_W-1:0]  job_rdata;
  logic              job_empty;
  logic              job_pop;
  logic [JCNT_W-1:0] job_count;
  result_t           result;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Sizes are held clamped to 1..maximum.
  always_comb begin
    cfg_w_ext = WCMP_W'(cfg_data);
    cfg_h_ext = HCMP_W'(cfg_data);
    if (cfg_data == '0) begin
      w_clamped = DIM_W'(1);
      h_clamped = HDIM_W'(1);
    end else begin
      w_clamped = (cfg_w_ext > WCMP_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(cfg_w_ext);
      h_clamped = (cfg_h_ext > HCMP_W'(MAX_HEIGHT)) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(cfg_h_ext);
    end
  end

  // Register writes; other indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= W_RESET;
      frame_h <= H_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_w <= w_clamped;
        REG_FRAME_HEIGHT: frame_h <= h_clamped;
        default:          frame_w <= frame_w;
      endcase
    end
  end

  assign restart = cfg_write &&
                   ((cfg_index == REG_FRAME_WIDTH) || (cfg_index == REG_FRAME_HEIGHT));
  assign w_last  = CW'(frame_w - 1'b1);
  assign h_last  = RW'(frame_h - 1'b1);

  hsg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .restart       (restart),
    .w_last        (w_last),
    .h_last        (h_last),
    .push          (push),
    .height_sample (height_sample),
    .full          (full),
    .job_count     (job_count),
    .job_push      (job_push),
    .job_data      (job_wdata)
  );

  // Job queue between the classifier and the result engine.
  hsg_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_wdata),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty),
    .count (job_count)
  );

  hsg_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .frame_w   (frame_w),
    .frame_h   (frame_h),
    .job_data  (job_rdata),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign slope_x      = result.slope_x;
  assign slope_y      = result.slope_y;
  assign out_col      = result.out_col;
  assign out_row      = result.out_row;
  assign last_of_run  = result.last_of_run;
  assign end_of_frame = result.end_of_frame;

endmodule

// ===== rtl/core/hsg_checker.sv =====
module hsg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input logic signed [hsg_pkg::SLOPE_W-1:0] slope_x,
  input logic                               last_of_run,
  input logic                               end_of_frame
);

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for input.
  a_reset_open: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !full)
    else $error("input side full after reset");

  // The frame's last pixel is always the final result of its input beat.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_frame) |-> last_of_run)
    else $error("end of frame without last of run");

  // A result not taken stays on the ports.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(slope_x) && $stable(end_of_frame)))
    else $error("stalled result changed");

endmodule

bind heightmap_slope_gradient_unit hsg_checker u_hsg_checker (
  .clk          (clk),
  .rst          (rst),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .slope_x      (slope_x),
  .last_of_run  (last_of_run),
  .end_of_frame (end_of_frame)
);
